// ===== hw/rtl/fire_effect_spread_engine_top_macros.svh =====
// Assertion macros shared by the fire spread engine RTL.
`ifndef FIRE_EFFECT_SPREAD_ENGINE_TOP_MACROS_SVH
`define FIRE_EFFECT_SPREAD_ENGINE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define FESE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define FESE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FESE_ASSERT(lbl, clk, rst_n, prop, msg)
`define FESE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/fese_pkg.sv =====
// Package: frame geometry, codes, palette and controller/datapath link types.
`timescale 1ns / 1ps

package fese_pkg;

	localparam int FRAME_WIDTH  = 480;
	localparam int FRAME_HEIGHT = 272;
	localparam int STORE_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int BOTTOM_BASE  = (FRAME_HEIGHT - 1) * FRAME_WIDTH;

	localparam int ADDR_W  = $clog2(STORE_SIZE);
	localparam int COL_W   = $clog2(FRAME_WIDTH);
	localparam int ROW_W   = $clog2(FRAME_HEIGHT);
	localparam int COORD_W = 11;	// holds any frame dimension for compares

	localparam int HEAT_W = 6;
	localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd36;

	localparam logic REQ_SPREAD = 1'b0;
	localparam logic REQ_READ   = 1'b1;
	localparam logic RESP_ACK   = 1'b0;
	localparam logic RESP_DATA  = 1'b1;

	localparam logic [1:0] PICK_DECAY = 2'd1;
	localparam logic [1:0] PICK_MAX   = 2'd2;

	typedef struct packed {
		logic clear;		// clearing sweep writes one entry
		logic accept_sp;	// spread beat taken, fetch cursor pixel
		logic accept_rd;	// read beat taken, form address
		logic rd_issue;		// fetch read pixel
		logic rd_out;		// load read response
		logic sp_wb;		// write target, advance cursor, load ack
	} fese_cmd_t;

	typedef struct packed {
		logic clr_last;
	} fese_sts_t;

	function automatic logic [31:0] palette(input logic [HEAT_W-1:0] lvl);
		logic [31:0] c;
		unique case (lvl)
			6'd0:    c = 32'hFF070707;
			6'd1:    c = 32'hFF1F0707;
			6'd2:    c = 32'hFF2F0F07;
			6'd3:    c = 32'hFF470F07;
			6'd4:    c = 32'hFF571707;
			6'd5:    c = 32'hFF671F07;
			6'd6:    c = 32'hFF771F07;
			6'd7:    c = 32'hFF8F2707;
			6'd8:    c = 32'hFF9F2F07;
			6'd9:    c = 32'hFFAF3F07;
			6'd10:   c = 32'hFFBF4707;
			6'd11:   c = 32'hFFC74707;
			6'd12:   c = 32'hFFDF4F07;
			6'd13:   c = 32'hFFDF5707;
			6'd14:   c = 32'hFFDF5707;
			6'd15:   c = 32'hFFD75F07;
			6'd16:   c = 32'hFFD75F07;
			6'd17:   c = 32'hFFD7670F;
			6'd18:   c = 32'hFFCF6F0F;
			6'd19:   c = 32'hFFCF770F;
			6'd20:   c = 32'hFFCF7F0F;
			6'd21:   c = 32'hFFCF8717;
			6'd22:   c = 32'hFFC78717;
			6'd23:   c = 32'hFFC78F17;
			6'd24:   c = 32'hFFC7971F;
			6'd25:   c = 32'hFFBF9F1F;
			6'd26:   c = 32'hFFBF9F1F;
			6'd27:   c = 32'hFFBFA727;
			6'd28:   c = 32'hFFBFA727;
			6'd29:   c = 32'hFFBFAF2F;
			6'd30:   c = 32'hFFB7AF2F;
			6'd31:   c = 32'hFFB7B72F;
			6'd32:   c = 32'hFFB7B737;
			6'd33:   c = 32'hFFCFCF6F;
			6'd34:   c = 32'hFFDFDF9F;
			6'd35:   c = 32'hFFEFEFC7;
			default: c = 32'hFFFFFFFF;	// 36 and anything hotter
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/fese_ctrl.sv =====
// Controller: clear sweep, request dispatch and step sequencing.
`timescale 1ns / 1ps

module fese_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               req_type,
	input  fese_pkg::fese_sts_t sts,
	output fese_pkg::fese_cmd_t cmd,
	output logic               busy
);
	import fese_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SPREAD = 5'b00100,
		ST_RADDR  = 5'b01000,
		ST_RMEM   = 5'b10000
	} fese_state_t;

	fese_state_t state_q, state_d;
	logic        accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_READ) begin
						cmd.accept_rd = 1'b1;
						state_d       = ST_RADDR;
					end else begin
						cmd.accept_sp = 1'b1;
						state_d       = ST_SPREAD;
					end
				end
			end
			ST_SPREAD: begin
				cmd.sp_wb = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_RADDR: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_RMEM;
			end
			ST_RMEM: begin
				cmd.rd_out = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

endmodule

// ===== hw/rtl/fese_dp.sv =====
// Datapath: heat memory, cursor, address math, palette and response registers.
`timescale 1ns / 1ps

module fese_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  fese_pkg::fese_cmd_t cmd,
	output fese_pkg::fese_sts_t sts,
	input  logic [1:0]          rand_pick,
	input  logic [8:0]          read_col,
	input  logic [8:0]          read_row,
	output logic                valid,
	output logic                resp_kind,
	output logic [31:0]         pixel_color,
	output logic [5:0]          intensity,
	output logic                pass_done
);
	import fese_pkg::*;

	logic [HEAT_W-1:0] heat_mem [STORE_SIZE];

	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] cursor_addr_q;
	logic [COL_W-1:0]  cursor_col_q;
	logic [ROW_W-1:0]  cursor_row_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              in_frame_q;
	logic [1:0]        pick_q;
	logic [HEAT_W-1:0] mem_rd_q;

	logic              valid_q;
	logic              kind_q;
	logic [31:0]       color_q;
	logic [HEAT_W-1:0] level_q;
	logic              done_q;

	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_wa, mem_ra;
	logic [HEAT_W-1:0] mem_wd;

	logic [ADDR_W-1:0] above_addr;
	logic [ADDR_W:0]   tgt_ext;
	logic              last_row, last_col;

	assign sts.clr_last = (clr_addr_q == ADDR_W'(STORE_SIZE - 1));

	// Pixel one row up; cursor never sits in row 0 so this stays in range.
	assign above_addr = cursor_addr_q - ADDR_W'(FRAME_WIDTH);
	// Sideways target; sign bit marks the one write that falls off the front.
	assign tgt_ext    = ({1'b0, above_addr} + (ADDR_W + 1)'(1)) - (ADDR_W + 1)'(pick_q);
	assign last_row   = (cursor_row_q == ROW_W'(FRAME_HEIGHT - 1));
	assign last_col   = (cursor_col_q == COL_W'(FRAME_WIDTH - 1));

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_addr_q;
		mem_wd = '0;
		if (cmd.clear) begin
			mem_we = 1'b1;
			mem_wd = (clr_addr_q >= ADDR_W'(BOTTOM_BASE)) ? HEAT_MAX : '0;
		end else if (cmd.sp_wb) begin
			if (mem_rd_q == '0) begin
				mem_we = 1'b1;
				mem_wa = above_addr;
			end else begin
				mem_we = !tgt_ext[ADDR_W];
				mem_wa = tgt_ext[ADDR_W-1:0];
				mem_wd = mem_rd_q - ((pick_q == PICK_DECAY) ? 6'd1 : 6'd0);
			end
		end
	end

	assign mem_re = cmd.accept_sp | cmd.rd_issue;
	assign mem_ra = cmd.rd_issue ? rd_addr_q : cursor_addr_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			heat_mem[mem_wa] <= mem_wd;
		if (mem_re)
			mem_rd_q <= heat_mem[mem_ra];
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.accept_sp)
			pick_q <= (rand_pick > PICK_MAX) ? PICK_MAX : rand_pick;
		if (cmd.accept_rd) begin
			rd_addr_q  <= ADDR_W'(read_row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(read_col);
			in_frame_q <= (COORD_W'(read_col) < COORD_W'(FRAME_WIDTH)) &&
			              (COORD_W'(read_row) < COORD_W'(FRAME_HEIGHT));
		end
	end

	// Clear sweep counter and column-major cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q    <= '0;
			cursor_col_q  <= '0;
			cursor_row_q  <= ROW_W'(1);
			cursor_addr_q <= ADDR_W'(FRAME_WIDTH);
		end else begin
			if (cmd.clear)
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (cmd.sp_wb) begin
				if (last_row) begin
					cursor_row_q <= ROW_W'(1);
					if (last_col) begin
						cursor_col_q  <= '0;
						cursor_addr_q <= ADDR_W'(FRAME_WIDTH);
					end else begin
						cursor_col_q  <= cursor_col_q + COL_W'(1);
						cursor_addr_q <= ADDR_W'(FRAME_WIDTH) + ADDR_W'(cursor_col_q)
						                 + ADDR_W'(1);
					end
				end else begin
					cursor_row_q  <= cursor_row_q + ROW_W'(1);
					cursor_addr_q <= cursor_addr_q + ADDR_W'(FRAME_WIDTH);
				end
			end
		end
	end

	// Response registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= cmd.sp_wb | cmd.rd_out;
	end

	always_ff @(posedge clk) begin
		if (cmd.sp_wb) begin
			kind_q  <= RESP_ACK;
			color_q <= '0;
			level_q <= '0;
			done_q  <= last_row && last_col;
		end else if (cmd.rd_out) begin
			kind_q  <= RESP_DATA;
			color_q <= in_frame_q ? palette(mem_rd_q) : '0;
			level_q <= in_frame_q ? mem_rd_q : '0;
			done_q  <= 1'b0;
		end
	end

	assign valid       = valid_q;
	assign resp_kind   = kind_q;
	assign pixel_color = color_q;
	assign intensity   = level_q;
	assign pass_done   = done_q;

endmodule

// ===== hw/rtl/fire_effect_spread_engine_top.sv =====
// Top level of the fire spread engine: controller, datapath and checks.
`timescale 1ns / 1ps
`include "fire_effect_spread_engine_top_macros.svh"

// Fire spread engine. Holds a FRAME_WIDTH x FRAME_HEIGHT frame of 6-bit fire
// intensities in one on-chip memory (one write and one synchronous read per
// cycle). After reset the block runs a clearing sweep over all FRAME_WIDTH *
// FRAME_HEIGHT entries (130560 at 480 x 272), one entry per cycle, writing 0
// everywhere and 36 into the bottom row; busy stays high until it ends.
// A beat is taken at a rising edge with start high and busy low.
//   Spread step (req_type 0): a memory read of the cursor pixel followed by
//     the write of its target.
//   Pixel read (req_type 1): address multiply, memory read, palette lookup.
// Each beat yields exactly one result beat: valid is high for one cycle and
// the payload is only good in that cycle. There is no back-pressure on the
// result side, so the receiver must take every beat as it comes. The result
// of a spread step is registered at its write step, that of a read at its palette lookup.
// A spread step at column 0, row 1 with pick 2 writes nothing if the cursor
// pixel is not 0; pick 3 acts as 2. Off-frame reads give intensity and color 0.

module fire_effect_spread_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [1:0]  rand_pick,
	input  logic [8:0]  read_col,
	input  logic [8:0]  read_row,
	output logic        valid,
	output logic        resp_kind,
	output logic [31:0] pixel_color,
	output logic [5:0]  intensity,
	output logic        pass_done
);
	import fese_pkg::*;

	fese_cmd_t cmd;
	fese_sts_t sts;

	fese_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	fese_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rand_pick   (rand_pick),
		.read_col    (read_col),
		.read_row    (read_row),
		.valid       (valid),
		.resp_kind   (resp_kind),
		.pixel_color (pixel_color),
		.intensity   (intensity),
		.pass_done   (pass_done)
	);

	// A result beat is only ever shown while the engine is free again.
	`FESE_ASSERT_ALWAYS(a_valid_idle, clk, valid |-> !busy, "result beat while busy")
	// Results never come back to back.
	`FESE_ASSERT(a_valid_gap, clk, arst_n, valid |=> !valid, "back-to-back result beats")
	// A spread step is answered with an acknowledge beat.
	`FESE_ASSERT(a_spread_lat, clk, arst_n,
		(start && !busy && req_type == REQ_SPREAD) |-> ##2 (valid && resp_kind == RESP_ACK),
		"spread step acknowledge missing")
	// A read is answered with a data beat.
	`FESE_ASSERT(a_read_lat, clk, arst_n,
		(start && !busy && req_type == REQ_READ) |-> ##3 (valid && resp_kind == RESP_DATA),
		"read data missing")

endmodule
